/* sv/bde_pkg.sv */
// Shared types and constants for the button debounce event detector.
package bde_pkg;

  localparam int unsigned DebounceTicksDefault = 3;
  localparam int unsigned SettleWidth = 4;
  localparam int unsigned CountWidth = 8;
  localparam logic [SettleWidth-1:0] SettleMax = '1;
  localparam logic [CountWidth-1:0] CountMax = '1;
  localparam logic [CountWidth-1:0] CountTargetReset = 8'd1;

  localparam int unsigned ApbAddrWidth = 3;
  localparam int unsigned ApbDataWidth = 32;
  localparam logic RegFireMode = 1'b0;
  localparam logic RegCountTarget = 1'b1;

  typedef enum logic [1:0] {
    CMD_EDGE     = 2'd0,
    CMD_DEBOUNCE = 2'd1,
    CMD_SECOND   = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    MODE_IGNORE    = 3'd0,
    MODE_PRESS     = 3'd1,
    MODE_RELEASE   = 3'd2,
    MODE_BOTH      = 3'd3,
    MODE_NTH_PRESS = 3'd4,
    MODE_NTH_REL   = 3'd5,
    MODE_HOLD_ONCE = 3'd6,
    MODE_HOLD_REP  = 3'd7
  } mode_e;

  typedef struct packed {
    mode_e                 trigger_mode;
    logic [CountWidth-1:0] count_target;
  } cfg_t;

  typedef struct packed {
    logic fire;
    logic stable_level;
  } result_t;

  function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] v);
    sat_inc = (v == CountMax) ? v : v + 1'b1;
  endfunction

endpackage

/* sv/bde_regs.sv */
// APB configuration registers of the button debounce event detector.
module bde_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [bde_pkg::ApbAddrWidth-1:0]     paddr,
  input  logic [bde_pkg::ApbDataWidth-1:0]     pwdata,
  output logic [bde_pkg::ApbDataWidth-1:0]     prdata,
  output logic                                 pready,
  output bde_pkg::cfg_t                        cfg_o
);

  bde_pkg::mode_e                  trigger_mode_q;
  logic [bde_pkg::CountWidth-1:0]  count_target_q;
  logic                            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trigger_mode_q <= bde_pkg::MODE_IGNORE;
      count_target_q <= bde_pkg::CountTargetReset;
    end else if (wr_en) begin
      if (paddr[2] == bde_pkg::RegFireMode) begin
        trigger_mode_q <= bde_pkg::mode_e'(pwdata[2:0]);
      end else begin
        count_target_q <= pwdata[bde_pkg::CountWidth-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == bde_pkg::RegFireMode) begin
      prdata = {29'd0, trigger_mode_q};
    end else begin
      prdata = {24'd0, count_target_q};
    end
  end

  assign cfg_o.trigger_mode = trigger_mode_q;
  assign cfg_o.count_target = count_target_q;

endmodule

/* sv/bde_core.sv */
// Debounce state, event counters and hold timer, updated once per item.
module bde_core #(
  parameter int unsigned DEBOUNCE_TICKS = bde_pkg::DebounceTicksDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  bde_pkg::cmd_e      cmd_i,
  input  logic               pin_i,
  input  bde_pkg::cfg_t      cfg_i,
  output bde_pkg::result_t   res_o
);

  localparam logic [bde_pkg::SettleWidth-1:0] SettleTarget =
    bde_pkg::SettleWidth'(DEBOUNCE_TICKS);

  logic                              debouncing_q, debouncing_d;
  logic                              expected_q, expected_d;
  logic [bde_pkg::SettleWidth-1:0]   settle_q, settle_d;
  logic                              stable_q, stable_d;
  logic [bde_pkg::CountWidth-1:0]    press_q, press_d;
  logic [bde_pkg::CountWidth-1:0]    release_q, release_d;
  logic [bde_pkg::CountWidth-1:0]    held_q, held_d;
  logic                              timing_q, timing_d;
  logic                              fire;
  logic [bde_pkg::CountWidth-1:0]    cnt_next;
  logic [bde_pkg::CountWidth-1:0]    held_next;

  always_comb begin
    debouncing_d = debouncing_q;
    expected_d   = expected_q;
    settle_d     = settle_q;
    stable_d     = stable_q;
    press_d      = press_q;
    release_d    = release_q;
    held_d       = held_q;
    timing_d     = timing_q;
    fire         = 1'b0;
    cnt_next     = '0;
    held_next    = bde_pkg::sat_inc(held_q);

    unique case (cmd_i)
      bde_pkg::CMD_EDGE: begin
        if (!debouncing_q) begin
          debouncing_d = pin_i ^ stable_q;
          expected_d   = pin_i;
        end
      end
      bde_pkg::CMD_DEBOUNCE: begin
        if (debouncing_q) begin
          if (settle_q == SettleTarget) begin
            debouncing_d = 1'b0;
            settle_d     = '0;
            if (expected_q == pin_i) begin
              stable_d = expected_q;
              unique case (cfg_i.trigger_mode)
                bde_pkg::MODE_PRESS:   fire = expected_q;
                bde_pkg::MODE_RELEASE: fire = !expected_q;
                bde_pkg::MODE_BOTH:    fire = 1'b1;
                bde_pkg::MODE_NTH_PRESS: begin
                  cnt_next = expected_q ? bde_pkg::sat_inc(press_q) : press_q;
                  fire     = (cnt_next == cfg_i.count_target);
                  press_d  = fire ? '0 : cnt_next;
                end
                bde_pkg::MODE_NTH_REL: begin
                  cnt_next  = expected_q ? release_q : bde_pkg::sat_inc(release_q);
                  fire      = (cnt_next == cfg_i.count_target);
                  release_d = fire ? '0 : cnt_next;
                end
                bde_pkg::MODE_HOLD_ONCE, bde_pkg::MODE_HOLD_REP: begin
                  held_d   = '0;
                  timing_d = expected_q;
                end
                default: fire = 1'b0;
              endcase
            end
          end else if (settle_q != bde_pkg::SettleMax) begin
            settle_d = settle_q + 1'b1;
          end
        end
      end
      bde_pkg::CMD_SECOND: begin
        if (timing_q) begin
          fire = (cfg_i.count_target <= held_next);
          if (fire && cfg_i.trigger_mode == bde_pkg::MODE_HOLD_REP) begin
            held_next = '0;
          end
          if (cfg_i.count_target <= held_next) begin
            held_d   = '0;
            timing_d = 1'b0;
          end else begin
            held_d = held_next;
          end
        end
      end
      default: fire = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debouncing_q <= 1'b0;
      expected_q   <= 1'b0;
      settle_q     <= '0;
      stable_q     <= 1'b0;
      press_q      <= '0;
      release_q    <= '0;
      held_q       <= '0;
      timing_q     <= 1'b0;
    end else if (step_i) begin
      debouncing_q <= debouncing_d;
      expected_q   <= expected_d;
      settle_q     <= settle_d;
      stable_q     <= stable_d;
      press_q      <= press_d;
      release_q    <= release_d;
      held_q       <= held_d;
      timing_q     <= timing_d;
    end
  end

  assign res_o.fire         = fire;
  assign res_o.stable_level = stable_d;

endmodule

/* sv/button_debounce_event_detector.sv */
// Top level of the push-button debouncer with press, release and hold events.
//
// Input stream (s_axis_*): one transfer per event. tuser carries the command
// (pin edge, 10 ms debounce tick, one-second tick); tdata bit 0 carries the
// raw pin level sampled with it.
// Output stream (m_axis_*): exactly one transfer per input transfer, in order.
// tdata bit 0 is fire, bit 1 is the debounced level after the event.
// Configuration: APB registers trigger_mode at 0x0 and count_target at 0x4, to be
// written by the user only while no event is in flight; the block does not enforce it.
// Path: each event passes the input register, then the result register, whose
// valid drives the output. Throughput: one event per cycle while the receiver
// does not stall; the state update is a single pass of short counters and
// compares between the two registers.
// Reset: valid flags and core state clear, the button reads released, trigger_mode is 0 and
// count_target is 1.
// Receiver stall: the result register holds, the input register fills, and
// s_axis_tready drops only when both are full.
module button_debounce_event_detector #(
  parameter int unsigned DEBOUNCE_TICKS = bde_pkg::DebounceTicksDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,   // [0] pin_level
  input  logic [1:0]                        s_axis_tuser,   // [1:0] command
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [7:0]                        m_axis_tdata,   // [0] fire, [1] stable_level
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bde_pkg::ApbAddrWidth-1:0]  paddr,
  input  logic [bde_pkg::ApbDataWidth-1:0]  pwdata,
  output logic [bde_pkg::ApbDataWidth-1:0]  prdata,
  output logic                              pready
);

  bde_pkg::cfg_t     cfg;
  bde_pkg::result_t  res;
  logic              in_valid_q;
  bde_pkg::cmd_e     cmd_q;
  logic              pin_q;
  logic              out_valid_q;
  bde_pkg::result_t  out_q;
  logic              out_free;
  logic              step;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_q <= bde_pkg::cmd_e'(s_axis_tuser);
      pin_q <= s_axis_tdata[0];
    end
    if (step) begin
      out_q <= res;
    end
  end

  bde_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bde_core #(
    .DEBOUNCE_TICKS (DEBOUNCE_TICKS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .cmd_i  (cmd_q),
    .pin_i  (pin_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_q.stable_level, out_q.fire};

endmodule
